>>> rtl/aabbpc_pkg.sv
package aabbpc_pkg;

    localparam int MAX_BOXES_DEF = 16;
    localparam int POS_W         = 16;
    localparam int SIZE_W        = 12;
    localparam int INDEX_W       = 4;
    localparam int WIDE_W        = 18;

    // One stored box: left/top position and size.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
    } box_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_LD_A,
        ST_CMP,
        ST_MOVE,
        ST_WB_A,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

    function automatic logic signed [WIDE_W-1:0] pos_ext(input logic [POS_W-1:0] v);
        pos_ext = $signed({{(WIDE_W-POS_W){v[POS_W-1]}}, v});
    endfunction

    function automatic logic signed [WIDE_W-1:0] size_ext(input logic [SIZE_W-1:0] v);
        size_ext = $signed({{(WIDE_W-SIZE_W){1'b0}}, v});
    endfunction

    // Clamp a widened position back into the signed 16-bit range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        if (v > 18'sd32767)
        begin
            sat_pos = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            sat_pos = 16'sh8000;
        end
        else
        begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage

>>> rtl/aabb_pairwise_collision_resolve.sv
// Channel  | Handshake              | Fields
// ---------+------------------------+---------------------------------------------
// load     | start & !busy          | in_x, in_y, box_width, box_height, last
// result   | result_valid (1 cycle) | box_index, out_x, out_y, end_of_set
//
// A box without last is written straight to the RAM; busy stays low, so boxes may
// load back to back. A box with last starts the pass: per outer index i, box i is
// read (RD_A) and loaded (LD_A), then each pair is compared (CMP) and moved (MOVE)
// through the single read port of the box RAM, and box i is written back (WB_A).
// Then OUT_RD and OUT_EMIT stream out the results, one per cycle.
// rst_n clears the state machine, box count and result strobe; the RAM keeps
// its contents. The receiver cannot stall: each result shows for one cycle.
module aabb_pairwise_collision_resolve #(
    parameter int MAX_BOXES = aabbpc_pkg::MAX_BOXES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [aabbpc_pkg::POS_W-1:0] in_x,
    input  logic signed [aabbpc_pkg::POS_W-1:0] in_y,
    input  logic [aabbpc_pkg::SIZE_W-1:0]       box_width,
    input  logic [aabbpc_pkg::SIZE_W-1:0]       box_height,
    input  logic                                last,
    output logic                                result_valid,
    output logic [aabbpc_pkg::INDEX_W-1:0]      box_index,
    output logic signed [aabbpc_pkg::POS_W-1:0] out_x,
    output logic signed [aabbpc_pkg::POS_W-1:0] out_y,
    output logic                                end_of_set
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int ENT_W = $bits(aabbpc_pkg::box_entry_t);
    localparam int W     = aabbpc_pkg::WIDE_W;

    aabbpc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;

    // Box i of the current outer pass, kept in flops across its pairs.
    aabbpc_pkg::box_entry_t a_reg, a_next;
    // Box j captured at compare time, with its compare results.
    aabbpc_pkg::box_entry_t b_reg, b_next;
    logic                   hit_reg, hit_next;
    logic                   altx_reg, altx_next;
    logic                   alty_reg, alty_next;
    logic signed [W-1:0]    ox_reg, ox_next;
    logic signed [W-1:0]    oy_reg, oy_next;

    logic                             result_valid_reg, result_valid_next;
    logic [IDX_W-1:0]                 box_index_reg, box_index_next;
    logic signed [aabbpc_pkg::POS_W-1:0] out_x_reg, out_x_next;
    logic signed [aabbpc_pkg::POS_W-1:0] out_y_reg, out_y_next;
    logic                             end_of_set_reg, end_of_set_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    aabbpc_pkg::box_entry_t mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ENT_W-1:0]       mem_rdata;
    aabbpc_pkg::box_entry_t rd_box;

    logic                   accept;
    logic                   room;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       n_after_load;
    logic [CNT_W-1:0]       i_inc;
    logic [CNT_W-1:0]       j_inc;
    logic                   j_more;
    logic                   i_more;
    logic                   emit_last;

    // compare stage
    logic signed [W-1:0]    ax, ay, bx, by, a_re, a_be, b_re, b_be;
    // move stage
    logic                   use_x;
    logic signed [W-1:0]    h;
    logic signed [W-1:0]    pa, pb, na, nb;
    logic signed [aabbpc_pkg::POS_W-1:0] na_sat, nb_sat;
    logic [IDX_W+aabbpc_pkg::INDEX_W-1:0] index_wide;

    aabbpc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_box = aabbpc_pkg::box_entry_t'(mem_rdata);

    assign busy         = (state_reg != aabbpc_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign room         = (count_reg < CNT_W'(MAX_BOXES));
    assign count_inc    = count_reg + CNT_W'(1);
    assign n_after_load = room ? count_inc : count_reg;
    assign i_inc        = CNT_W'(i_reg) + CNT_W'(1);
    assign j_inc        = CNT_W'(j_reg) + CNT_W'(1);
    assign j_more       = (j_inc < count_reg);
    assign i_more       = ((i_inc + CNT_W'(1)) < count_reg);
    assign emit_last    = (i_inc == count_reg);

    // Edges at full width: no saturation in the overlap test.
    assign ax   = aabbpc_pkg::pos_ext(a_reg.x);
    assign ay   = aabbpc_pkg::pos_ext(a_reg.y);
    assign bx   = aabbpc_pkg::pos_ext(rd_box.x);
    assign by   = aabbpc_pkg::pos_ext(rd_box.y);
    assign a_re = ax + aabbpc_pkg::size_ext(a_reg.w);
    assign a_be = ay + aabbpc_pkg::size_ext(a_reg.h);
    assign b_re = bx + aabbpc_pkg::size_ext(rd_box.w);
    assign b_be = by + aabbpc_pkg::size_ext(rd_box.h);

    // Overlaps are never negative on a hit, so a plain arithmetic shift halves them.
    // A tie in overlap picks the y axis; equal positions push box a positive.
    assign use_x  = (ox_reg < oy_reg);
    assign h      = use_x ? (ox_reg >>> 1) : (oy_reg >>> 1);
    assign pa     = use_x ? aabbpc_pkg::pos_ext(a_reg.x) : aabbpc_pkg::pos_ext(a_reg.y);
    assign pb     = use_x ? aabbpc_pkg::pos_ext(b_reg.x) : aabbpc_pkg::pos_ext(b_reg.y);
    assign na     = (use_x ? altx_reg : alty_reg) ? (pa - h) : (pa + h);
    assign nb     = (use_x ? altx_reg : alty_reg) ? (pb + h) : (pb - h);
    assign na_sat = aabbpc_pkg::sat_pos(na);
    assign nb_sat = aabbpc_pkg::sat_pos(nb);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aabbpc_pkg::ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = (n_after_load > CNT_W'(1)) ? aabbpc_pkg::ST_RD_A
                                                            : aabbpc_pkg::ST_OUT_RD;
                end
            end
            aabbpc_pkg::ST_RD_A:     state_next = aabbpc_pkg::ST_LD_A;
            aabbpc_pkg::ST_LD_A:     state_next = aabbpc_pkg::ST_CMP;
            aabbpc_pkg::ST_CMP:      state_next = aabbpc_pkg::ST_MOVE;
            aabbpc_pkg::ST_MOVE:
            begin
                state_next = j_more ? aabbpc_pkg::ST_CMP : aabbpc_pkg::ST_WB_A;
            end
            aabbpc_pkg::ST_WB_A:
            begin
                state_next = i_more ? aabbpc_pkg::ST_RD_A : aabbpc_pkg::ST_OUT_RD;
            end
            aabbpc_pkg::ST_OUT_RD:   state_next = aabbpc_pkg::ST_OUT_EMIT;
            aabbpc_pkg::ST_OUT_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = aabbpc_pkg::ST_IDLE;
                end
            end
            default:                 state_next = aabbpc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next        = count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        hit_next          = hit_reg;
        altx_next         = altx_reg;
        alty_next         = alty_reg;
        ox_next           = ox_reg;
        oy_next           = oy_reg;
        result_valid_next = 1'b0;
        box_index_next    = box_index_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        end_of_set_next   = end_of_set_reg;
        mem_we            = 1'b0;
        mem_waddr         = count_reg[IDX_W-1:0];
        mem_wdata         = '{x: in_x, y: in_y, w: box_width, h: box_height};
        mem_re            = 1'b0;
        mem_raddr         = i_reg;

        unique case (state_reg)
            aabbpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // Drop the box when the set is full; last still starts the pass.
                    if (room)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                    end
                    i_next = '0;
                end
            end
            aabbpc_pkg::ST_RD_A:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg;
            end
            aabbpc_pkg::ST_LD_A:
            begin
                a_next    = rd_box;
                j_next    = i_inc[IDX_W-1:0];
                mem_re    = 1'b1;
                mem_raddr = i_inc[IDX_W-1:0];
            end
            aabbpc_pkg::ST_CMP:
            begin
                b_next    = rd_box;
                hit_next  = (ax <= b_re) && (a_re >= bx) && (ay <= b_be) && (a_be >= by);
                altx_next = (ax < bx);
                alty_next = (ay < by);
                ox_next   = (ax > bx) ? (b_re - ax) : (a_re - bx);
                oy_next   = (ay > by) ? (b_be - ay) : (a_be - by);
            end
            aabbpc_pkg::ST_MOVE:
            begin
                // Write box j back now; box i stays in flops until its pass ends.
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = b_reg;
                if (hit_reg)
                begin
                    if (use_x)
                    begin
                        a_next.x    = na_sat;
                        mem_wdata.x = nb_sat;
                    end
                    else
                    begin
                        a_next.y    = na_sat;
                        mem_wdata.y = nb_sat;
                    end
                end
                if (j_more)
                begin
                    j_next    = j_inc[IDX_W-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = j_inc[IDX_W-1:0];
                end
            end
            aabbpc_pkg::ST_WB_A:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = a_reg;
                i_next    = i_more ? i_inc[IDX_W-1:0] : '0;
            end
            aabbpc_pkg::ST_OUT_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg;
            end
            aabbpc_pkg::ST_OUT_EMIT:
            begin
                result_valid_next = 1'b1;
                box_index_next    = i_reg;
                out_x_next        = rd_box.x;
                out_y_next        = rd_box.y;
                end_of_set_next   = emit_last;
                if (emit_last)
                begin
                    count_next = '0;
                    i_next     = '0;
                end
                else
                begin
                    // Prefetch the next box so results stream one per cycle.
                    i_next    = i_inc[IDX_W-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = i_inc[IDX_W-1:0];
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= aabbpc_pkg::ST_IDLE;
            count_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        hit_reg        <= hit_next;
        altx_reg       <= altx_next;
        alty_reg       <= alty_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        box_index_reg  <= box_index_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        end_of_set_reg <= end_of_set_next;
    end

    // Report the low bits of the load index, zero-extended for small sets.
    assign index_wide   = {{aabbpc_pkg::INDEX_W{1'b0}}, box_index_reg};
    assign box_index    = index_wide[aabbpc_pkg::INDEX_W-1:0];
    assign result_valid = result_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign end_of_set   = end_of_set_reg;

endmodule

>>> rtl/aabbpc_ram.sv
module aabbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/aabbpc_checker.sv
module aabbpc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               last,
    input logic                               result_valid,
    input logic [aabbpc_pkg::INDEX_W-1:0]     box_index,
    input logic                               end_of_set
);

    // A box without last never causes a result on the next cycle.
    a_no_result_after_plain_load: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last |=> !result_valid)
        else $error("result after a load without last");

    // A box with last always starts the pass.
    a_last_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last |=> busy)
        else $error("last did not start the pass");

    // Results stream back to back in load order.
    a_results_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !end_of_set |=>
            result_valid && (box_index == aabbpc_pkg::INDEX_W'($past(box_index) + 1'b1)))
        else $error("result stream broken or out of order");

    // The final result shows while idle and ends the run; a new box may load with it.
    a_end_stops_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_set |-> !busy ##1 !result_valid)
        else $error("results continue after end of set");

    // The block goes idle only together with the final result.
    a_idle_with_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && end_of_set)
        else $error("busy dropped without the final result");

endmodule

bind aabb_pairwise_collision_resolve aabbpc_checker u_aabbpc_checker (.*);
